@@ hw/rtl/tsc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, widths and constants for the Taylor sine/cosine unit.
// Used by tsc_reduce, tsc_series, taylor_sine_cosine_unit and the testbench; no dependencies.
package tsc_pkg;

  localparam int unsigned MAX_TERMS = 16;
  localparam int unsigned CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int unsigned CFG_W     = 5;
  localparam logic [CFG_W-1:0] NUM_TERMS_RESET = CFG_W'(10);

  localparam int unsigned ANGLE_W = 32;
  localparam int unsigned VALUE_W = 18;
  localparam int unsigned OUT_DATA_W = 24;

  localparam int unsigned PI_Q16     = 205887;
  localparam int unsigned TWO_PI_Q16 = 411775;
  localparam logic signed [ANGLE_W:0] PI_EXT = (ANGLE_W + 1)'(PI_Q16);

  // Range reduction: k = ceil(d / 2pi) through a reciprocal with one correction.
  localparam int unsigned WRAP_SHIFT   = 44;
  localparam int unsigned WRAP_RECIP_W = 26;
  localparam logic [WRAP_RECIP_W-1:0] WRAP_RECIP =
    WRAP_RECIP_W'((64'd1 << WRAP_SHIFT) / 64'(TWO_PI_Q16));
  localparam int unsigned WRAP_PROD_W = ANGLE_W + WRAP_RECIP_W;
  localparam int unsigned WRAP_Q_W    = WRAP_PROD_W - WRAP_SHIFT;
  localparam int unsigned WRAP_QD_W   = ANGLE_W + 1;

  // Series datapath widths.
  localparam int unsigned RED_W    = 19;
  localparam int unsigned MAG_W    = 18;
  localparam int unsigned ASQ_W    = 2 * MAG_W;
  localparam int unsigned SQ_W     = 32;
  localparam int unsigned TERM_W   = 31;
  localparam int unsigned PROD_W   = TERM_W + SQ_W;
  localparam int unsigned T_W      = PROD_W + 1 - 28;
  localparam int unsigned U_W      = 33;
  localparam int unsigned RECIP_W  = U_W + 1;
  localparam int unsigned RLO_W    = 17;
  localparam int unsigned RHI_W    = RECIP_W - RLO_W;
  localparam int unsigned PP_W     = U_W + RLO_W;
  localparam int unsigned QP_W     = U_W + RECIP_W;
  localparam int unsigned E_W      = 12;
  localparam int unsigned SUM_W    = 33 + $clog2(MAX_TERMS);
  localparam int unsigned FMAG_W   = SUM_W - 11;

  localparam logic [FMAG_W-1:0] VALUE_POS_LIM = FMAG_W'((1 << (VALUE_W - 1)) - 1);
  localparam logic [FMAG_W-1:0] VALUE_NEG_LIM = FMAG_W'(1 << (VALUE_W - 1));
  localparam logic [VALUE_W-1:0] VALUE_MAX = VALUE_W'((1 << (VALUE_W - 1)) - 1);
  localparam logic [VALUE_W-1:0] VALUE_MIN = VALUE_W'(1 << (VALUE_W - 1));

  localparam logic OP_SINE   = 1'b0;
  localparam logic OP_COSINE = 1'b1;

  typedef struct packed {
    logic valid;
    logic op;
    logic neg;
  } tsc_ctl_t;

  // Half of the index divisor: sine (2i)(2i+1)/2, cosine (2i-1)(2i)/2.
  function automatic int unsigned div_half(int unsigned i, logic is_cos);
    int unsigned h;
    h = is_cos ? i * (2 * i - 1) : i * (2 * i + 1);
    return h;
  endfunction

endpackage

@@ hw/rtl/tsc_reduce.sv @@
`timescale 1ns / 1ps
// Five-stage reduction of a Q15.16 angle into [-pi, pi] by whole turns of 2pi.
// Depends on tsc_pkg.
module tsc_reduce (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   ce,
  input  tsc_pkg::tsc_ctl_t                      in_ctl,
  input  logic signed [tsc_pkg::ANGLE_W-1:0]     in_angle,
  output tsc_pkg::tsc_ctl_t                      out_ctl,
  output logic signed [tsc_pkg::RED_W-1:0]       out_r
);
  import tsc_pkg::*;

  logic signed [ANGLE_W:0]   ext;
  logic                      hi_next;
  logic                      lo_next;
  logic signed [ANGLE_W:0]   diff;
  logic [ANGLE_W-1:0]        m_next;

  tsc_ctl_t                  r1_ctl, r2_ctl, r3_ctl, r4_ctl;
  logic signed [ANGLE_W-1:0] r1_angle, r2_angle, r3_angle, r4_angle;
  logic                      r1_hi, r2_hi, r3_hi, r4_hi;
  logic [ANGLE_W-1:0]        r1_m, r2_m, r3_m;
  logic [WRAP_PROD_W-1:0]    r2_prod;
  logic [WRAP_QD_W-1:0]      r3_qd;
  logic [ANGLE_W-1:0]        r4_kd;

  logic [WRAP_Q_W-1:0]       q_est;
  logic [WRAP_QD_W-1:0]      rem;
  logic [WRAP_QD_W-1:0]      kd_next;
  logic signed [ANGLE_W+1:0] rr;

  always_comb begin
    ext     = {in_angle[ANGLE_W-1], in_angle};
    hi_next = ext > PI_EXT;
    lo_next = ext < -PI_EXT;
    if (hi_next) begin
      diff = ext - PI_EXT;
    end else if (lo_next) begin
      diff = -PI_EXT - ext;
    end else begin
      diff = '0;
    end
    m_next = diff[ANGLE_W-1:0] + ANGLE_W'(TWO_PI_Q16 - 1);
  end

  assign q_est = r2_prod[WRAP_SHIFT +: WRAP_Q_W];
  assign rem   = {1'b0, r3_m} - r3_qd;
  assign kd_next = (rem >= WRAP_QD_W'(TWO_PI_Q16)) ? r3_qd + WRAP_QD_W'(TWO_PI_Q16) : r3_qd;
  assign rr = r4_hi ? (ANGLE_W + 2)'(r4_angle) - $signed({2'b00, r4_kd})
                    : (ANGLE_W + 2)'(r4_angle) + $signed({2'b00, r4_kd});

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_ctl  <= '0;
      r2_ctl  <= '0;
      r3_ctl  <= '0;
      r4_ctl  <= '0;
      out_ctl <= '0;
    end else if (ce) begin
      r1_ctl  <= in_ctl;
      r2_ctl  <= r1_ctl;
      r3_ctl  <= r2_ctl;
      r4_ctl  <= r3_ctl;
      out_ctl <= r4_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      r1_angle <= in_angle;
      r1_hi    <= hi_next;
      r1_m     <= m_next;

      r2_angle <= r1_angle;
      r2_hi    <= r1_hi;
      r2_m     <= r1_m;
      r2_prod  <= WRAP_PROD_W'(r1_m) * WRAP_PROD_W'(WRAP_RECIP);

      r3_angle <= r2_angle;
      r3_hi    <= r2_hi;
      r3_m     <= r2_m;
      r3_qd    <= WRAP_QD_W'(q_est) * WRAP_QD_W'(TWO_PI_Q16);

      r4_angle <= r3_angle;
      r4_hi    <= r3_hi;
      r4_kd    <= kd_next[ANGLE_W-1:0];

      out_r    <= rr[RED_W-1:0];
    end
  end

endmodule

@@ hw/rtl/tsc_series.sv @@
`timescale 1ns / 1ps
// Pipelined Maclaurin series: per term, one accumulate-and-multiply stage and three
// more stages to build the next term (round, reciprocal multiply, shift). Uses tsc_pkg.
module tsc_series (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               ce,
  input  logic [tsc_pkg::CNT_W-1:0]          terms,
  input  tsc_pkg::tsc_ctl_t                  in_ctl,
  input  logic [tsc_pkg::SQ_W-1:0]           in_sq,
  input  logic [tsc_pkg::TERM_W-1:0]         in_term,
  output tsc_pkg::tsc_ctl_t                  out_ctl,
  output logic signed [tsc_pkg::SUM_W-1:0]   out_sum
);
  import tsc_pkg::*;

  tsc_ctl_t                lk_ctl  [0:MAX_TERMS-1];
  logic [SQ_W-1:0]         lk_sq   [0:MAX_TERMS-1];
  logic [TERM_W-1:0]       lk_term [0:MAX_TERMS-1];
  logic signed [SUM_W-1:0] lk_sum  [0:MAX_TERMS-1];

  assign lk_ctl[0]  = in_ctl;
  assign lk_sq[0]   = in_sq;
  assign lk_term[0] = in_term;
  assign lk_sum[0]  = '0;

  for (genvar k = 0; k < MAX_TERMS; k++) begin : g_term
    localparam int unsigned IDX = k + 1;

    logic signed [SUM_W-1:0] term_ext;
    logic signed [SUM_W-1:0] sum_next;
    tsc_ctl_t                a_ctl;
    logic signed [SUM_W-1:0] a_sum;

    assign term_ext = $signed({{(SUM_W - TERM_W){1'b0}}, lk_term[k]});
    always_comb begin
      if (terms >= CNT_W'(IDX)) begin
        sum_next = (k % 2 == 0) ? lk_sum[k] + term_ext : lk_sum[k] - term_ext;
      end else begin
        sum_next = lk_sum[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        a_ctl <= '0;
      end else if (ce) begin
        a_ctl <= lk_ctl[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        a_sum <= sum_next;
      end
    end

    if (k == MAX_TERMS - 1) begin : g_last
      assign out_ctl = a_ctl;
      assign out_sum = a_sum;
    end else begin : g_next
      localparam int unsigned ES = div_half(IDX, OP_SINE);
      localparam int unsigned EC = div_half(IDX, OP_COSINE);
      localparam int unsigned LS = $clog2(ES);
      localparam int unsigned LC = $clog2(EC);
      localparam int unsigned SS = U_W + LS;
      localparam int unsigned SC = U_W + LC;
      localparam logic [RECIP_W-1:0] MS =
        RECIP_W'(((80'd1 << SS) + 80'(ES) - 80'd1) / 80'(ES));
      localparam logic [RECIP_W-1:0] MC =
        RECIP_W'(((80'd1 << SC) + 80'(EC) - 80'd1) / 80'(EC));

      logic [PROD_W-1:0]       a_prod;
      logic [SQ_W-1:0]         a_sq;

      tsc_ctl_t                b_ctl;
      logic signed [SUM_W-1:0] b_sum;
      logic [SQ_W-1:0]         b_sq;
      logic [U_W-1:0]          b_u;

      tsc_ctl_t                c_ctl;
      logic signed [SUM_W-1:0] c_sum;
      logic [SQ_W-1:0]         c_sq;
      logic [PP_W-1:0]         c_pl;
      logic [PP_W-1:0]         c_ph;

      tsc_ctl_t                d_ctl;
      logic signed [SUM_W-1:0] d_sum;
      logic [SQ_W-1:0]         d_sq;
      logic [TERM_W-1:0]       d_term;

      logic [PROD_W:0]         rnd;
      logic [T_W-1:0]          t_half;
      logic [RECIP_W-1:0]      recip;
      logic [QP_W-1:0]         qprod;
      logic [TERM_W-1:0]       q_next;

      assign rnd    = {1'b0, a_prod} + ((PROD_W + 1)'(1) << 27);
      assign t_half = rnd[PROD_W:28] + T_W'(a_ctl.op ? E_W'(EC) : E_W'(ES));
      assign recip  = b_ctl.op ? MC : MS;
      assign qprod  = {c_ph, {RLO_W{1'b0}}} + QP_W'(c_pl);
      assign q_next = c_ctl.op ? TERM_W'(qprod >> SC) : TERM_W'(qprod >> SS);

      always_ff @(posedge clk) begin
        if (rst) begin
          b_ctl <= '0;
          c_ctl <= '0;
          d_ctl <= '0;
        end else if (ce) begin
          b_ctl <= a_ctl;
          c_ctl <= b_ctl;
          d_ctl <= c_ctl;
        end
      end

      always_ff @(posedge clk) begin
        if (ce) begin
          a_prod <= PROD_W'(lk_term[k]) * PROD_W'(lk_sq[k]);
          a_sq   <= lk_sq[k];

          b_sum  <= a_sum;
          b_sq   <= a_sq;
          b_u    <= t_half[U_W:1];

          c_sum  <= b_sum;
          c_sq   <= b_sq;
          c_pl   <= PP_W'(b_u) * PP_W'(recip[RLO_W-1:0]);
          c_ph   <= PP_W'(b_u) * PP_W'(recip[RECIP_W-1:RLO_W]);

          d_sum  <= c_sum;
          d_sq   <= c_sq;
          d_term <= q_next;
        end
      end

      assign lk_ctl[k+1]  = d_ctl;
      assign lk_sum[k+1]  = d_sum;
      assign lk_sq[k+1]   = d_sq;
      assign lk_term[k+1] = d_term;
    end
  end

endmodule

@@ hw/rtl/taylor_sine_cosine_unit.sv @@
`timescale 1ns / 1ps
// Top level of the Taylor-series sine/cosine unit: stream ports, term count
// register, magnitude and square stages, output rounding and skid. Uses tsc_pkg.
//
//   channel   dir   handshake                       payload
//   s_axis    in    s_axis_tvalid / s_axis_tready   tuser: operation, tdata: angle
//   m_axis    out   m_axis_tvalid / m_axis_tready   tdata: value
//   cfg       in    cfg_wr_en                       cfg_wr_data: num_terms
//
// One request per cycle is accepted while s_axis_tready is high; a request passes
// through 5 reduction, 3 square and 61 series stages, sign and output registers.
// rst clears all valid bits, the skid and num_terms (back to 10).
// A stall of m_axis fills the output register and then the skid; only a full
// skid holds the pipeline and drops s_axis_tready.
module taylor_sine_cosine_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [tsc_pkg::ANGLE_W-1:0]          s_axis_tdata,   // [31:0] angle
  input  logic                                 s_axis_tuser,   // [0] operation
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [tsc_pkg::OUT_DATA_W-1:0]       m_axis_tdata,   // [17:0] value, rest zero
  input  logic                                 cfg_wr_en,
  input  logic [tsc_pkg::CFG_W-1:0]            cfg_wr_data
);
  import tsc_pkg::*;

  logic                    ce;
  logic [CFG_W-1:0]        num_terms;
  logic [CNT_W-1:0]        terms;

  tsc_ctl_t                in_ctl;
  tsc_ctl_t                red_ctl;
  logic signed [RED_W-1:0] red_r;

  tsc_ctl_t                p1_ctl, p2_ctl, p3_ctl;
  logic [MAG_W-1:0]        p1_a, p2_a;
  logic [ASQ_W-1:0]        p2_asq;
  logic [SQ_W-1:0]         p3_sq;
  logic [TERM_W-1:0]       p3_term;
  logic [RED_W-1:0]        neg_r;
  logic [ASQ_W-1:0]        asq_rnd;

  tsc_ctl_t                ser_ctl;
  logic signed [SUM_W-1:0] ser_sum;

  tsc_ctl_t                f1_ctl;
  logic signed [SUM_W-1:0] f1_sum;
  logic [SUM_W-1:0]        f_abs;
  logic [SUM_W:0]          f_rnd;
  logic [FMAG_W-1:0]       f_mag;
  logic [VALUE_W-1:0]      f_value;

  logic                    out_valid;
  logic [VALUE_W-1:0]      out_value;
  logic                    skid_valid;
  logic [VALUE_W-1:0]      skid_value;

  assign ce            = ~skid_valid;
  assign s_axis_tready = ce;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W - VALUE_W){1'b0}}, out_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      num_terms <= NUM_TERMS_RESET;
    end else if (cfg_wr_en) begin
      num_terms <= cfg_wr_data;
    end
  end

  assign terms = (int'(num_terms) > int'(MAX_TERMS)) ? CNT_W'(MAX_TERMS) : CNT_W'(num_terms);

  assign in_ctl = '{valid: s_axis_tvalid, op: s_axis_tuser, neg: 1'b0};

  tsc_reduce u_reduce (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_ctl   (in_ctl),
    .in_angle ($signed(s_axis_tdata)),
    .out_ctl  (red_ctl),
    .out_r    (red_r)
  );

  assign neg_r   = -red_r;
  assign asq_rnd = p2_asq + ASQ_W'(8);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_ctl <= '0;
      p2_ctl <= '0;
      p3_ctl <= '0;
    end else if (ce) begin
      p1_ctl <= '{valid: red_ctl.valid, op: red_ctl.op, neg: red_r[RED_W-1]};
      p2_ctl <= p1_ctl;
      p3_ctl <= p2_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      p1_a    <= red_r[RED_W-1] ? neg_r[MAG_W-1:0] : red_r[MAG_W-1:0];
      p2_a    <= p1_a;
      p2_asq  <= ASQ_W'(p1_a) * ASQ_W'(p1_a);
      p3_sq   <= asq_rnd[ASQ_W-1:4];
      p3_term <= (p2_ctl.op == OP_COSINE) ? (TERM_W'(1) << 28) : (TERM_W'(p2_a) << 12);
    end
  end

  tsc_series u_series (
    .clk     (clk),
    .rst     (rst),
    .ce      (ce),
    .terms   (terms),
    .in_ctl  (p3_ctl),
    .in_sq   (p3_sq),
    .in_term (p3_term),
    .out_ctl (ser_ctl),
    .out_sum (ser_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_ctl <= '0;
    end else if (ce) begin
      f1_ctl <= ser_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      f1_sum <= (ser_ctl.op == OP_SINE && ser_ctl.neg) ? -ser_sum : ser_sum;
    end
  end

  always_comb begin
    f_abs = f1_sum[SUM_W-1] ? SUM_W'(-f1_sum) : SUM_W'(f1_sum);
    f_rnd = {1'b0, f_abs} + (SUM_W + 1)'(2048);
    f_mag = f_rnd[SUM_W:12];
    if (f1_sum[SUM_W-1]) begin
      f_value = (f_mag > VALUE_NEG_LIM) ? VALUE_MIN : VALUE_W'(-f_mag);
    end else begin
      f_value = (f_mag > VALUE_POS_LIM) ? VALUE_MAX : VALUE_W'(f_mag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_axis_tready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= f1_ctl.valid;
      end
    end else if (ce && f1_ctl.valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_axis_tready || !out_valid) begin
      out_value <= skid_valid ? skid_value : f_value;
    end else if (ce && f1_ctl.valid) begin
      skid_value <= f_value;
    end
  end

endmodule

@@ test/taylor_sine_cosine_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for taylor_sine_cosine_unit: a queue-fed stream driver,
// a checking monitor and a bit-exact Taylor sine/cosine predictor. Uses tsc_pkg.
module taylor_sine_cosine_unit_tb;

  localparam longint HALF_TURN = 205887;
  localparam longint FULL_TURN = 411775;
  localparam logic [tsc_pkg::CFG_W-1:0] TERMS_AT_RESET = 5'd10;
  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = 100;

  typedef struct packed {
    logic                        op;
    logic [tsc_pkg::ANGLE_W-1:0] angle;
  } angle_req_t;

  typedef struct packed {
    logic                        op;
    logic [tsc_pkg::ANGLE_W-1:0] angle;
    logic [tsc_pkg::VALUE_W-1:0] value;
  } value_exp_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [tsc_pkg::ANGLE_W-1:0]     s_axis_tdata = '0;
  logic                            s_axis_tuser = tsc_pkg::OP_SINE;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [tsc_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
  logic                            cfg_wr_en = 1'b0;
  logic [tsc_pkg::CFG_W-1:0]       cfg_wr_data = '0;

  angle_req_t angle_q[$];
  value_exp_t value_q[$];
  logic [tsc_pkg::CFG_W-1:0] terms_model = TERMS_AT_RESET;
  int  mismatches = 0;
  int  tx_gap = 0;
  int  rx_stall = 0;
  int  rx_hold_len = 0;
  int  idle_cycles = 0;
  bit  tx_idle_en = 1'b1;
  bit  rx_idle_en = 1'b1;

  taylor_sine_cosine_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [tsc_pkg::VALUE_W-1:0] taylor_value(
    logic op, logic [tsc_pkg::ANGLE_W-1:0] angle_bits, logic [tsc_pkg::CFG_W-1:0] terms);
    longint r;
    longint acc;
    longint v;
    longint unsigned a, sq, term, d, mag, n, i;
    bit neg, minus;
    r = longint'(signed'(angle_bits));
    if (r > HALF_TURN)
      r -= ((r - HALF_TURN + FULL_TURN - 1) / FULL_TURN) * FULL_TURN;
    else if (r < -HALF_TURN)
      r += ((-HALF_TURN - r + FULL_TURN - 1) / FULL_TURN) * FULL_TURN;
    neg = r < 0;
    a = neg ? -r : r;
    sq = (a * a + 64'd8) >> 4;
    term = (op == tsc_pkg::OP_COSINE) ? (64'd1 << 28) : (a << 12);
    n = (terms > tsc_pkg::MAX_TERMS) ? 64'(tsc_pkg::MAX_TERMS) : 64'(terms);
    acc = 0;
    minus = 1'b0;
    for (i = 1; i <= n; i++) begin
      d = (op == tsc_pkg::OP_COSINE) ? (2 * i - 1) * (2 * i) : (2 * i) * (2 * i + 1);
      acc = minus ? acc - longint'(term) : acc + longint'(term);
      minus = !minus;
      term = (term * sq + (64'd1 << 27)) >> 28;
      term = (term + d / 2) / d;
    end
    if (op == tsc_pkg::OP_SINE && neg)
      acc = -acc;
    if (acc < 0) begin
      mag = (unsigned'(-acc) + 64'd2048) >> 12;
      v = (mag > 131072) ? -131072 : -longint'(mag);
    end else begin
      mag = (unsigned'(acc) + 64'd2048) >> 12;
      v = (mag > 131071) ? 131071 : longint'(mag);
    end
    return v[tsc_pkg::VALUE_W-1:0];
  endfunction

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  function automatic logic [tsc_pkg::ANGLE_W-1:0] random_angle();
    int r;
    int k;
    int v;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      v = int'($urandom_range(0, 411774)) - 205887;
    end else if (r < 65) begin
      k = int'($urandom_range(0, 10)) - 5;
      v = k * 205887 + int'($urandom_range(0, 8)) - 4;
    end else if (r < 80) begin
      v = int'($urandom_range(0, 1 << 21));
      if ($urandom_range(0, 1)) v = -v;
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  // Request side: hold the current request until accepted, then present the next.
  always @(posedge clk) begin : angle_driver
    logic nv;
    angle_req_t req;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      tx_gap <= 0;
    end else begin
      nv = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        value_q.push_back('{op: s_axis_tuser, angle: s_axis_tdata,
                            value: taylor_value(s_axis_tuser, s_axis_tdata, terms_model)});
        nv = 1'b0;
      end
      if (!nv) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
        end else if (angle_q.size() > 0) begin
          req = angle_q.pop_front();
          s_axis_tdata <= req.angle;
          s_axis_tuser <= req.op;
          nv = 1'b1;
          tx_gap <= tx_idle_en ? pick_pause() : 0;
        end
      end
      s_axis_tvalid <= nv;
    end
  end

  // Result side: check each accepted result against the oldest expectation.
  always @(posedge clk) begin : value_monitor
    logic nr;
    value_exp_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (value_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result %h at %0t", m_axis_tdata, $realtime);
        end else begin
          want = value_q.pop_front();
          if (m_axis_tdata !== {{(tsc_pkg::OUT_DATA_W - tsc_pkg::VALUE_W){1'b0}}, want.value})
          begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch op=%0d angle=%h: expected %h, got %h at %0t",
                       want.op, want.angle, want.value, m_axis_tdata, $realtime);
          end
        end
      end
      if (rx_hold_len > 0) begin
        rx_hold_len--;
        nr = 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        nr = 1'b0;
      end else begin
        nr = 1'b1;
        if (rx_idle_en) rx_stall = pick_pause();
      end
      m_axis_tready <= nr;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic wait_idle();
    @(negedge clk);
    while (angle_q.size() != 0 || s_axis_tvalid || value_q.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_terms(input logic [tsc_pkg::CFG_W-1:0] terms);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= terms;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    terms_model = terms;
  endtask

  task automatic push_random(input int count);
    int i;
    for (i = 0; i < count; i++)
      angle_q.push_back('{op: 1'($urandom_range(0, 1)), angle: random_angle()});
  endtask

  task automatic run_phase(input logic [tsc_pkg::CFG_W-1:0] terms, input int count,
                           input bit tx_idle, input bit rx_idle);
    wait_idle();
    write_terms(terms);
    tx_idle_en = tx_idle;
    rx_idle_en = rx_idle;
    @(negedge clk);
    push_random(count);
    wait_idle();
  endtask

  initial begin : sequencer
    int edge_angles[12];
    int i;
    edge_angles = '{0, 205887, -205887, 205888, -205888, 411775, 102944, -102944,
                    32'h7FFF_FFFF, 32'h8000_0000, 1, -1};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (i = 0; i < 12; i++) begin
      angle_q.push_back('{op: tsc_pkg::OP_SINE, angle: edge_angles[i]});
      angle_q.push_back('{op: tsc_pkg::OP_COSINE, angle: edge_angles[i]});
    end
    wait_idle();

    run_phase(5'd0, 60, 1'b1, 1'b1);
    run_phase(5'd1, 80, 1'b1, 1'b0);
    run_phase(5'd16, 80, 1'b0, 1'b1);
    run_phase(5'd31, 80, 1'b1, 1'b1);
    run_phase(5'd17, 60, 1'b0, 1'b0);
    run_phase(5'd2, 80, 1'b1, 1'b1);

    // Back-pressure: hold the result side while requests keep coming.
    write_terms(5'($urandom_range(3, 15)));
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    @(negedge clk);
    rx_hold_len = 400;
    push_random(150);
    wait_idle();

    // Drain mid-stream before resuming requests.
    write_terms(5'($urandom_range(0, 31)));
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    @(negedge clk);
    push_random(60);
    wait_idle();
    push_random(60);
    wait_idle();

    run_phase(5'($urandom_range(0, 31)), 80, 1'b1, 1'b1);
    run_phase(5'd10, 60, 1'b1, 1'b1);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && value_q.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/tsc_pkg.sv
hw/rtl/tsc_reduce.sv
hw/rtl/tsc_series.sv
hw/rtl/taylor_sine_cosine_unit.sv
test/taylor_sine_cosine_unit_tb.sv
